/* hw/rtl/igc_pkg.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// igc_pkg: shared definitions for the interleaved gamma codec
// Operation and result codes, stream widths and the result record type.
//------------------------------------------------------------------------------
package igc_pkg;

    // Default width of the coded integers.
    localparam int VALUE_BITS_DEF = 64;

    // Beat widths on the two stream sides.
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 80;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;

    // Operation carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_ENC_VALUE = 2'd0,
        OP_ENC_FLUSH = 2'd1,
        OP_DEC_BYTE  = 2'd2,
        OP_DEC_END   = 2'd3
    } op_t;

    // Kind of a result beat, carried in the output tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE   = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    // One result beat.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [63:0] value;
        logic        error;
        logic        last;
    } result_t;

endpackage

/* hw/rtl/interleaved_gamma_codec_unit.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// interleaved_gamma_codec_unit: interleaved Elias gamma encoder and decoder
// Encodes positive integers into a packed bit stream and decodes it back.
//------------------------------------------------------------------------------
// Usage:
// The slave side takes one operation per beat: tuser selects encode value,
// encode flush, decode byte or decode end. An accepted beat is held in an
// item register and worked off from there; each result goes through a single
// output register on the master side, with tlast on the final result of the
// operation. An operation holds the item register until its last result has
// gone out, one result per cycle while the output register is free, so decoding
// runs at one byte a cycle unless a byte completes more than one value or the
// receiver stalls, and encoding a value yields one result per finished byte.
// The next beat is taken in the cycle the current item finishes. The first result
// passes through the item register and then the output register to the master side.
// Reset clears the pending encoder bits and the decoder, and empties both registers.
// When the receiver stalls, the result waits in the output register, the
// item register holds its item, and a new beat is taken only if the item
// in hand needs no further result slot.
//------------------------------------------------------------------------------
module interleaved_gamma_codec_unit #(
    parameter int VALUE_BITS = igc_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input beat.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // Fields from bit 0: value_in[63:0], byte_in[71:64].
    input  logic [igc_pkg::S_DATA_W-1:0] s_tdata,
    // Fields from bit 0: op[1:0].
    input  logic [igc_pkg::OP_W-1:0]     s_tuser,
    // Result beat.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // Fields from bit 0: byte_out[7:0], value_out[71:8], error[72], zeros above.
    output logic [igc_pkg::M_DATA_W-1:0] m_tdata,
    // Fields from bit 0: kind[1:0].
    output logic [igc_pkg::KIND_W-1:0]   m_tuser,
    output logic                         m_tlast
);
    import igc_pkg::*;

    localparam int CODE_W = 2 * VALUE_BITS;
    localparam int SW     = CODE_W + 7;
    localparam int LEN_W  = $clog2(SW + 1);
    localparam int IDX_W  = $clog2(VALUE_BITS);
    localparam int TOP_W  = $clog2(VALUE_BITS);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(VALUE_BITS - 1);
    localparam logic [LEN_W-1:0] LEN_BYTE = LEN_W'(8);

    // Item register.
    logic                    item_vld_reg, item_vld_next;
    op_t                     op_reg;
    logic [CODE_W-1:0]       code_reg;
    logic [LEN_W-1:0]        clen_reg;
    logic                    zero_reg;
    logic                    merged_reg, merged_next;
    logic [7:0]              rem_reg, rem_next;
    logic [3:0]              rem_cnt_reg, rem_cnt_next;

    // Encoder pending stream, first bit at bit 0.
    logic [SW-1:0]           stream_reg, stream_next;
    logic [LEN_W-1:0]        slen_reg, slen_next;

    // Decoder state.
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    expect_reg, expect_next;

    // Output register.
    logic                    out_vld_reg;
    result_t                 out_reg;

    // Step control.
    logic                    out_free;
    logic                    st_has_out;
    logic                    st_done;
    logic                    step_fire;
    logic                    s_accept;
    result_t                 st_res;

    // Code expansion of the incoming value.
    logic [VALUE_BITS-1:0]   in_val;
    logic [VALUE_BITS-1:0]   in_above;
    logic [VALUE_BITS-1:0]   in_lead;
    logic [CODE_W-1:0]       in_code;
    logic [TOP_W-1:0]        in_top;

    // Decode scan results.
    logic                    dec_found1;
    logic                    dec_found2;
    logic                    dec_ev_err;
    logic [VALUE_BITS-1:0]   dec_ev_val;
    logic [3:0]              dec_cut;
    logic [VALUE_BITS-1:0]   dec_acc_end;
    logic [IDX_W-1:0]        dec_idx_end;
    logic                    dec_exp_end;

    // Encode merge of the item code into the pending stream.
    logic [SW-1:0]           enc_stream_m;
    logic [LEN_W-1:0]        enc_slen_m;
    logic [7:0]              enc_byte;
    logic [7:0]              flush_byte;

    assign out_free  = !out_vld_reg || m_tready;
    assign step_fire = item_vld_reg && (!st_has_out || out_free);
    assign s_tready  = !item_vld_reg || (step_fire && st_done);
    assign s_accept  = s_tvalid && s_tready;

    // Each value bit below the leading one gives a zero flag and the data
    // bit; the leading one itself gives the closing one bit.
    always_comb
    begin
        in_val = s_tdata[VALUE_BITS-1:0];
        in_top = '0;
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            in_above[i]      = |(in_val >> (i + 1));
            in_lead[i]       = in_val[i] & ~in_above[i];
            in_code[2*i]     = in_lead[i];
            in_code[2*i + 1] = in_val[i] & in_above[i];
            in_top           = in_top | (in_lead[i] ? TOP_W'(i) : '0);
        end
    end

    // Pending stream with this item's code appended, and the byte views.
    always_comb
    begin
        if (merged_reg)
        begin
            enc_stream_m = stream_reg;
            enc_slen_m   = slen_reg;
        end
        else
        begin
            enc_stream_m = stream_reg | (SW'(code_reg) << slen_reg[2:0]);
            enc_slen_m   = slen_reg + clen_reg;
        end
        for (int k = 0; k < 8; k++)
        begin
            enc_byte[7-k]   = enc_stream_m[k];
            flush_byte[7-k] = stream_reg[k];
        end
    end

    // Walk the remaining bits of the byte, MSB first, up to the first value
    // or error, and look on for a second one.
    always_comb
    begin : dec_scan
        logic [VALUE_BITS-1:0] a;
        logic [IDX_W-1:0]      ix;
        logic                  e;
        logic                  b;
        logic                  evt;
        logic                  err;
        logic [VALUE_BITS-1:0] val;
        a          = acc_reg;
        ix         = idx_reg;
        e          = expect_reg;
        dec_found1 = 1'b0;
        dec_found2 = 1'b0;
        dec_ev_err = 1'b0;
        dec_ev_val = '0;
        dec_cut    = '0;
        for (int j = 0; j < 8; j++)
        begin
            b   = rem_reg[3'(7 - j)];
            evt = 1'b0;
            err = 1'b0;
            val = '0;
            if ((4'(j) < rem_cnt_reg) && !dec_found2)
            begin
                if (e)
                begin
                    a  = a | (VALUE_BITS'(b) << ix);
                    ix = ix + IDX_W'(1);
                    e  = 1'b0;
                end
                else if (b)
                begin
                    evt = 1'b1;
                    val = a | (VALUE_BITS'(1) << ix);
                end
                else if (ix >= IDX_MAX)
                begin
                    evt = 1'b1;
                    err = 1'b1;
                end
                else
                begin
                    e = 1'b1;
                end
                if (evt)
                begin
                    if (!dec_found1)
                    begin
                        dec_found1 = 1'b1;
                        dec_ev_err = err;
                        dec_ev_val = val;
                        dec_cut    = 4'(j + 1);
                    end
                    else
                    begin
                        dec_found2 = 1'b1;
                    end
                    a  = '0;
                    ix = '0;
                    e  = 1'b0;
                end
            end
        end
        dec_acc_end = a;
        dec_idx_end = ix;
        dec_exp_end = e;
    end

    // One step of the item in hand: at most one result and the next state.
    always_comb
    begin
        st_has_out   = 1'b0;
        st_done      = 1'b1;
        st_res       = '0;
        stream_next  = stream_reg;
        slen_next    = slen_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        expect_next  = expect_reg;
        merged_next  = 1'b1;
        rem_next     = rem_reg;
        rem_cnt_next = rem_cnt_reg;
        case (op_reg)
            OP_ENC_VALUE:
            begin
                if (zero_reg)
                begin
                    st_has_out   = 1'b1;
                    st_res.kind  = KIND_STATUS;
                    st_res.error = 1'b1;
                end
                else if (enc_slen_m >= LEN_BYTE)
                begin
                    st_has_out       = 1'b1;
                    st_res.kind      = KIND_BYTE;
                    st_res.data_byte = enc_byte;
                    stream_next      = enc_stream_m >> 8;
                    slen_next        = enc_slen_m - LEN_BYTE;
                    st_done          = (slen_next < LEN_BYTE);
                end
                else
                begin
                    stream_next = enc_stream_m;
                    slen_next   = enc_slen_m;
                end
            end
            OP_ENC_FLUSH:
            begin
                st_has_out       = (slen_reg != '0);
                st_res.kind      = KIND_BYTE;
                st_res.data_byte = flush_byte;
                stream_next      = '0;
                slen_next        = '0;
            end
            OP_DEC_BYTE:
            begin
                st_has_out   = dec_found1;
                st_res.kind  = dec_ev_err ? KIND_STATUS : KIND_VALUE;
                st_res.value = dec_ev_err ? 64'd0 : 64'(dec_ev_val);
                st_res.error = dec_ev_err;
                st_done      = !dec_found2;
                rem_next     = rem_reg << dec_cut;
                rem_cnt_next = rem_cnt_reg - dec_cut;
                if (dec_found2)
                begin
                    acc_next    = '0;
                    idx_next    = '0;
                    expect_next = 1'b0;
                end
                else
                begin
                    acc_next    = dec_acc_end;
                    idx_next    = dec_idx_end;
                    expect_next = dec_exp_end;
                end
            end
            OP_DEC_END:
            begin
                st_has_out   = 1'b1;
                st_res.kind  = KIND_STATUS;
                st_res.error = (idx_reg != '0) || expect_reg;
                acc_next     = '0;
                idx_next     = '0;
                expect_next  = 1'b0;
            end
            default:
            begin
                st_done = 1'b1;
            end
        endcase
        st_res.last = st_done;
    end

    // Item register occupancy.
    always_comb
    begin
        if (s_accept)
        begin
            item_vld_next = 1'b1;
        end
        else if (step_fire && st_done)
        begin
            item_vld_next = 1'b0;
        end
        else
        begin
            item_vld_next = item_vld_reg;
        end
    end

    // Control state: occupancy, encoder and decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            stream_reg   <= '0;
            slen_reg     <= '0;
            acc_reg      <= '0;
            idx_reg      <= '0;
            expect_reg   <= 1'b0;
            op_reg       <= OP_ENC_FLUSH;
            merged_reg   <= 1'b0;
            rem_cnt_reg  <= '0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            if (step_fire)
            begin
                stream_reg <= stream_next;
                slen_reg   <= slen_next;
                acc_reg    <= acc_next;
                idx_reg    <= idx_next;
                expect_reg <= expect_next;
            end
            if (s_accept)
            begin
                op_reg      <= op_t'(s_tuser);
                merged_reg  <= 1'b0;
                rem_cnt_reg <= 4'd8;
            end
            else if (step_fire)
            begin
                merged_reg  <= merged_next;
                rem_cnt_reg <= rem_cnt_next;
            end
            if (step_fire && st_has_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            code_reg <= in_code;
            clen_reg <= LEN_W'({in_top, 1'b1});
            zero_reg <= (in_val == '0);
            rem_reg  <= s_tdata[71:64];
        end
        else if (step_fire)
        begin
            rem_reg <= rem_next;
        end
        if (step_fire && st_has_out)
        begin
            out_reg <= st_res;
        end
    end

    // Master side.
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_reg.error, out_reg.value, out_reg.data_byte};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // Pending encoder bits stay below a byte unless an encode is draining.
    a_enc_pending_short: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_vld_reg && (op_reg == OP_ENC_VALUE) && merged_reg) |-> (slen_reg < LEN_BYTE))
        else $error("encoder holds a full byte outside an encode item");

    // Stream bits beyond the pending length are always zero.
    a_enc_stream_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ((stream_reg >> slen_reg) == '0))
        else $error("stray bits above the pending stream length");

    // A flush leaves the encoder empty.
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && (op_reg == OP_ENC_FLUSH) && step_fire) |=> (slen_reg == '0))
        else $error("encoder not empty after flush");

    // The decoder never holds more data bits than a value can carry.
    a_dec_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg <= IDX_MAX))
        else $error("decoder bit index out of range");

    // A byte still in work always has bits left to scan.
    a_dec_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && (op_reg == OP_DEC_BYTE)) |->
            ((rem_cnt_reg != 4'd0) && (rem_cnt_reg <= 4'd8)))
        else $error("decode item without remaining bits");

endmodule

/* tb/igc_result_checker.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// igc_result_checker: result predictor and scoreboard for the gamma codec
// Watches both stream sides of the codec. Each accepted input beat is run
// through a bit-level model of the encoder and decoder, and the result beats
// it must cause are queued in order. Each accepted result beat is compared
// field by field against the oldest queued result. The number of failures
// and the number of results still owed are handed to the testbench top.
//------------------------------------------------------------------------------
module igc_result_checker
    import igc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // Input side of the codec.
    input  logic                s_tvalid,
    input  logic                s_tready,
    // Fields from bit 0: value_in[63:0], byte_in[71:64].
    input  logic [S_DATA_W-1:0] s_tdata,
    // Fields from bit 0: op[1:0].
    input  logic [OP_W-1:0]     s_tuser,
    // Result side of the codec.
    input  logic                m_tvalid,
    input  logic                m_tready,
    // Fields from bit 0: byte_out[7:0], value_out[71:8], error[72].
    input  logic [M_DATA_W-1:0] m_tdata,
    // Fields from bit 0: kind[1:0].
    input  logic [KIND_W-1:0]   m_tuser,
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  results_owed
);

    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

    // Model of the encoder: coded bits waiting to fill a byte, first at bit 7.
    logic [7:0]  enc_bits;
    int          enc_fill;

    // Model of the decoder: data bits gathered and what the next bit means.
    logic [63:0] dec_acc;
    int          dec_count;
    logic        dec_want_data;

    // Results owed by the codec, oldest first, and those of the current beat.
    result_t     owed_beats[$];
    result_t     step_beats[$];

    int          fails = 0;
    int          owed  = 0;

    assign fail_count   = fails;
    assign results_owed = owed;

    task automatic add_beat(input kind_t k, input logic [7:0] b, input logic [63:0] v,
                            input logic e);
        result_t r;
        r.kind      = k;
        r.data_byte = b;
        r.value     = v;
        r.error     = e;
        r.last      = 1'b0;
        step_beats.push_back(r);
    endtask

    task automatic clear_decoder();
        dec_acc       = '0;
        dec_count     = 0;
        dec_want_data = 1'b0;
    endtask

    // Append one coded bit; a full byte becomes a result.
    task automatic encode_bit(input logic b);
        enc_bits[7 - enc_fill] = b;
        enc_fill++;
        if (enc_fill == 8)
        begin
            add_beat(KIND_BYTE, enc_bits, '0, 1'b0);
            enc_bits = '0;
            enc_fill = 0;
        end
    endtask

    // Consume one coded bit: a data bit, a terminating one, or a zero flag.
    task automatic decode_bit(input logic b);
        if (dec_want_data)
        begin
            dec_acc[dec_count] = b;
            dec_count++;
            dec_want_data = 1'b0;
        end
        else if (b)
        begin
            add_beat(KIND_VALUE, 8'h00, dec_acc | (64'd1 << dec_count), 1'b0);
            clear_decoder();
        end
        else if (dec_count >= VALUE_BITS - 1)
        begin
            // A further data bit would not fit in the value width.
            add_beat(KIND_STATUS, 8'h00, '0, 1'b1);
            clear_decoder();
        end
        else
        begin
            dec_want_data = 1'b1;
        end
    endtask

    // Work out every result that one input beat causes and queue them.
    task automatic predict_beat(input op_t op, input logic [63:0] raw_value,
                                input logic [7:0] code_byte);
        logic [63:0] v;
        int          msb;
        logic        pending;
        result_t     r;
        step_beats.delete();
        case (op)
            OP_ENC_VALUE:
            begin
                v = raw_value & VALUE_MASK;
                if (v == '0)
                begin
                    add_beat(KIND_STATUS, 8'h00, '0, 1'b1);
                end
                else
                begin
                    msb = 0;
                    for (int i = 1; i < 64; i++)
                        if (v[i])
                            msb = i;
                    for (int i = 0; i < msb; i++)
                    begin
                        encode_bit(1'b0);
                        encode_bit(v[i]);
                    end
                    encode_bit(1'b1);
                end
            end
            OP_ENC_FLUSH:
            begin
                if (enc_fill != 0)
                    add_beat(KIND_BYTE, enc_bits, '0, 1'b0);
                enc_bits = '0;
                enc_fill = 0;
            end
            OP_DEC_BYTE:
            begin
                for (int i = 7; i >= 0; i--)
                    decode_bit(code_byte[i]);
            end
            default:
            begin
                pending = (dec_count != 0) || dec_want_data;
                clear_decoder();
                add_beat(KIND_STATUS, 8'h00, '0, pending);
            end
        endcase
        if (step_beats.size() > 0)
        begin
            r = step_beats[step_beats.size() - 1];
            r.last = 1'b1;
            step_beats[step_beats.size() - 1] = r;
        end
        foreach (step_beats[i])
            owed_beats.push_back(step_beats[i]);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fails++;
        end
    endtask

    // Compare result beats and predict on input beats at every clock edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            enc_bits = '0;
            enc_fill = 0;
            clear_decoder();
            owed_beats.delete();
            owed = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind      = kind_t'(m_tuser);
                got.data_byte = m_tdata[7:0];
                got.value     = m_tdata[71:8];
                got.error     = m_tdata[72];
                got.last      = m_tlast;
                if (owed_beats.size() == 0)
                begin
                    $error("result beat with nothing owed: kind %0d byte 0x%0h value 0x%0h",
                           got.kind, got.data_byte, got.value);
                    fails++;
                end
                else
                begin
                    want = owed_beats.pop_front();
                    check_field("kind", 64'(want.kind), 64'(got.kind));
                    check_field("byte_out", 64'(want.data_byte), 64'(got.data_byte));
                    check_field("value_out", want.value, got.value);
                    check_field("error", 64'(want.error), 64'(got.error));
                    check_field("last", 64'(want.last), 64'(got.last));
                end
            end
            if (s_tvalid && s_tready)
                predict_beat(op_t'(s_tuser), s_tdata[63:0], s_tdata[71:64]);
            owed = owed_beats.size();
        end
    end

endmodule

/* tb/interleaved_gamma_codec_unit_tb.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// interleaved_gamma_codec_unit_tb: stimulus and verdict for the gamma codec
// Drives a directed list of corner operations, then random operations in
// phases with and without sender gaps and receiver stalls. Decode bytes are
// mostly cut from freshly built gamma codes, with overlong codes, noise
// bytes and stray decode ends mixed in. A separate checker does the checking.
//------------------------------------------------------------------------------
module interleaved_gamma_codec_unit_tb;
    import igc_pkg::*;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                m_tlast;

    int                  fail_count;
    int                  results_owed;

    // Percent chance of a sender gap or receiver stall in each cycle.
    int                  idle_pct  = 0;
    int                  stall_pct = 0;

    // Coded bits waiting to be cut into decode bytes, first bit first.
    bit                  code_bits[$];

    interleaved_gamma_codec_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    igc_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Receiver backpressure.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Send one beat, with random gaps ahead of it, and wait for its handshake.
    // Called and left at a rising edge; s_tready is sampled at the falling edge.
    task automatic send_op(input op_t op, input logic [63:0] value,
                           input logic [7:0] code_byte);
        bit ready_seen;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {code_byte, value};
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
    endtask

    // Hold the sender off until every owed result has come out.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        return (v == '0) ? 64'd1 : v;
    endfunction

    // Append the gamma code of a positive value, low bits first.
    function automatic void append_gamma(input logic [63:0] v);
        int msb;
        msb = 0;
        for (int i = 1; i < 64; i++)
            if (v[i])
                msb = i;
        for (int i = 0; i < msb; i++)
        begin
            code_bits.push_back(1'b0);
            code_bits.push_back(v[i]);
        end
        code_bits.push_back(1'b1);
    endfunction

    // Append a code one data bit too long: 63 data bits and another zero flag.
    function automatic void append_overlong();
        for (int i = 0; i < 63; i++)
        begin
            code_bits.push_back(1'b0);
            code_bits.push_back(1'($urandom_range(0, 1)));
        end
        code_bits.push_back(1'b0);
    endfunction

    function automatic logic [7:0] next_code_byte();
        logic [7:0] b;
        while (code_bits.size() < 8)
        begin
            if ($urandom_range(0, 14) == 0)
                append_overlong();
            else
                append_gamma(rand_value());
        end
        for (int i = 7; i >= 0; i--)
            b[i] = code_bits.pop_front();
        return b;
    endfunction

    // One random operation; decode bytes mostly follow well-formed codes.
    task automatic random_op();
        int          pick;
        logic [63:0] noise;
        pick  = $urandom_range(0, 99);
        noise = {$urandom, $urandom};
        if (pick < 30)
        begin
            if ($urandom_range(0, 49) == 0)
                send_op(OP_ENC_VALUE, '0, 8'($urandom));
            else
                send_op(OP_ENC_VALUE, rand_value(), 8'($urandom));
        end
        else if (pick < 38)
        begin
            send_op(OP_ENC_FLUSH, noise, 8'($urandom));
        end
        else if (pick < 90)
        begin
            if ($urandom_range(0, 19) == 0)
                send_op(OP_DEC_BYTE, noise, 8'($urandom));
            else
                send_op(OP_DEC_BYTE, noise, next_code_byte());
        end
        else
        begin
            send_op(OP_DEC_END, noise, 8'($urandom));
            code_bits.delete();
        end
        if ($urandom_range(0, 39) == 0)
            wait_results_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: widest codes, zero value, empty flush, decoder edges.
        send_op(OP_ENC_VALUE, 64'd1, 8'h00);
        send_op(OP_ENC_VALUE, 64'd0, 8'hff);
        send_op(OP_ENC_VALUE, 64'h8000_0000_0000_0000, 8'h00);
        send_op(OP_ENC_VALUE, 64'hffff_ffff_ffff_ffff, 8'hff);
        send_op(OP_ENC_FLUSH, 64'h0, 8'h00);
        send_op(OP_ENC_FLUSH, 64'hffff_ffff_ffff_ffff, 8'hff);
        send_op(OP_ENC_VALUE, 64'd2, 8'h00);
        send_op(OP_ENC_VALUE, 64'd3, 8'h00);
        send_op(OP_ENC_FLUSH, 64'h0, 8'h00);
        send_op(OP_DEC_BYTE, 64'h0, 8'hff);
        send_op(OP_DEC_BYTE, 64'hffff_ffff_ffff_ffff, 8'h00);
        send_op(OP_DEC_END, 64'h0, 8'h00);
        send_op(OP_DEC_END, 64'h0, 8'h00);
        send_op(OP_DEC_BYTE, 64'h0, 8'h55);
        send_op(OP_DEC_BYTE, 64'h0, 8'h80);
        send_op(OP_DEC_END, 64'h0, 8'h00);
        send_op(OP_DEC_BYTE, 64'h0, 8'haa);
        send_op(OP_DEC_BYTE, 64'h0, 8'h7f);
        send_op(OP_DEC_END, 64'h0, 8'h00);
        send_op(OP_ENC_VALUE, 64'h5555_5555_5555_5555, 8'h00);
        send_op(OP_ENC_VALUE, 64'hffff_ffff_ffff_ffff, 8'h00);
        send_op(OP_ENC_FLUSH, 64'h0, 8'h00);
        wait_results_drained();

        // Random phases; the first decode bytes carry an overlong code.
        append_overlong();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 47;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 47;
                end
                default:
                begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
            endcase
            for (int n = 0; n < 50; n++)
                random_op();
        end

        stall_pct = 0;
        wait_results_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/igc_pkg.sv
hw/rtl/interleaved_gamma_codec_unit.sv
tb/igc_result_checker.sv
tb/interleaved_gamma_codec_unit_tb.sv
